FILE: hw/rtl/sle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants of the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int DEPTH       = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // widths fixed by the port list
  localparam int OPCODE_W    = 3;
  localparam int POSITION_W  = 4;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int CAP_W       = 5;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_READ    = 3'd3,
    OP_REVERSE = 3'd4,
    OP_SORT    = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  // register indexes of the configuration port
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_DELETE,
    CELL_TAG_INIT,
    CELL_STEP
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    cell_op_t               op;
    logic [IDX_W-1:0]       pos;
    logic [CNT_W-1:0]       count;
    logic                   parity;
    logic                   by_tag;
    logic [DATA_WIDTH-1:0]  word;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sle_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_cell
// One list entry. Shifts with its neighbors and does compare-exchange steps.
// ----------------------------------------------------------------------------
module sle_cell (
  input  wire                                   clk,
  input  wire  [sle_pkg::IDX_W-1:0]             idx,
  input  sle_pkg::cell_cmd_t                    cmd,
  input  wire  [sle_pkg::DATA_WIDTH-1:0]        left_word,
  input  wire  [sle_pkg::IDX_W-1:0]             left_tag,
  input  wire                                   left_swap,
  input  wire  [sle_pkg::DATA_WIDTH-1:0]        right_word,
  input  wire  [sle_pkg::IDX_W-1:0]             right_tag,
  output logic [sle_pkg::DATA_WIDTH-1:0]        word,
  output logic [sle_pkg::IDX_W-1:0]             tag,
  output logic                                  swap_right
);

  logic [sle_pkg::DATA_WIDTH-1:0] word_next;
  logic [sle_pkg::IDX_W-1:0]      tag_next;
  logic [sle_pkg::CNT_W-1:0]      idx_c;
  logic                           left_act;
  logic                           right_act;
  logic                           greater;

  assign idx_c = sle_pkg::CNT_W'(idx);

  // this cell is the lower member of a pair in the current round
  assign left_act  = (idx[0] == cmd.parity) &&
                     ((idx_c + sle_pkg::CNT_W'(1)) < cmd.count);
  // this cell is the upper member of a pair
  assign right_act = (idx_c != '0) && (idx[0] != cmd.parity) && (idx_c < cmd.count);

  // reverse orders by original position, descending
  assign greater = cmd.by_tag ? (tag < right_tag)
                              : ($signed(word) > $signed(right_word));

  assign swap_right = (cmd.op == sle_pkg::CELL_STEP) && left_act && greater;

  always_comb begin
    word_next = word;
    tag_next  = tag;
    case (cmd.op)
      sle_pkg::CELL_APPEND: begin
        if (idx_c == cmd.count) word_next = cmd.word;
      end
      sle_pkg::CELL_INSERT: begin
        if (idx == cmd.pos) begin
          word_next = cmd.word;
        end else if ((idx > cmd.pos) && (idx_c <= cmd.count)) begin
          word_next = left_word;
        end
      end
      sle_pkg::CELL_DELETE: begin
        if ((idx >= cmd.pos) && ((idx_c + sle_pkg::CNT_W'(1)) < cmd.count)) begin
          word_next = right_word;
        end
      end
      sle_pkg::CELL_TAG_INIT: begin
        tag_next = idx;
      end
      sle_pkg::CELL_STEP: begin
        if (swap_right) begin
          word_next = right_word;
          tag_next  = right_tag;
        end else if (right_act && left_swap) begin
          word_next = left_word;
          tag_next  = left_tag;
        end
      end
      default: begin
        word_next = word;
        tag_next  = tag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
    tag  <= tag_next;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sequential_list_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequential_list_engine_core
// Ordered list of signed words kept in a row of cells.
// ----------------------------------------------------------------------------
// One item is worked at a time and gives one result beat. Append, insert,
// delete and read finish in the cycle the item is taken: the row of cells
// shifts all entries in one step. Reverse and sort of a list with n >= 2
// entries load the tags and then run n odd-even compare-exchange rounds
// across the cells. The result then waits in a result slot and an output
// register, so the next item is taken as soon as the slot has moved on, even
// while the output beat is stalled. No clearing pass follows reset.
module sequential_list_engine_core (
  input  wire                                    clk,
  input  wire                                    rst,
  // configuration port
  input  wire                                    psel,
  input  wire                                    penable,
  input  wire                                    pwrite,
  input  wire  [sle_pkg::PADDR_W-1:0]            paddr,
  input  wire  [sle_pkg::PDATA_W-1:0]            pwdata,
  output logic [sle_pkg::PDATA_W-1:0]            prdata,
  output logic                                   pready,
  // input channel
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire  [sle_pkg::OPCODE_W-1:0]           opcode,
  input  wire  [sle_pkg::POSITION_W-1:0]         position,
  input  wire  signed [sle_pkg::VALUE_W-1:0]     value,
  // output channel
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic [sle_pkg::STATUS_W-1:0]           status,
  output logic signed [sle_pkg::VALUE_W-1:0]     read_data,
  output logic [sle_pkg::COUNT_OUT_W-1:0]        entry_count
);

  localparam int DEPTH = sle_pkg::DEPTH;
  localparam int DW    = sle_pkg::DATA_WIDTH;
  localparam int IW    = sle_pkg::IDX_W;
  localparam int CW    = sle_pkg::CNT_W;

  sle_pkg::state_t      state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        round, round_next;
  logic                 is_sort, is_sort_next;
  logic [sle_pkg::CAP_W-1:0] capacity;

  logic                 res_valid, res_valid_next;
  sle_pkg::status_t     res_status, res_status_next;
  logic [sle_pkg::VALUE_W-1:0] res_data, res_data_next;
  logic [CW-1:0]        res_count, res_count_next;

  sle_pkg::cell_cmd_t   cmd;
  logic                 accept;
  logic                 out_load;
  logic                 full;
  logic                 pos_ok;
  logic                 cfg_write;

  logic [DW-1:0]        word_chain [DEPTH];
  logic [IW-1:0]        tag_chain  [DEPTH];
  logic                 swap_chain [DEPTH];

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= sle_pkg::CAP_RESET;
    end else if (cfg_write && (paddr[2] == sle_pkg::REG_CAPACITY)) begin
      capacity <= pwdata[sle_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == sle_pkg::REG_CAPACITY) prdata = sle_pkg::PDATA_W'(capacity);
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign in_stall = (state != sle_pkg::ST_IDLE) || res_valid;
  assign accept   = in_valid && !in_stall;
  assign out_load = res_valid && (!out_valid || !out_stall);

  // capacity above the row depth counts as the depth
  assign full   = (int'(count) >= DEPTH) || (int'(count) >= int'(capacity));
  assign pos_ok = int'(position) < int'(count);

  always_comb begin
    state_next      = state;
    count_next      = count;
    round_next      = round;
    is_sort_next    = is_sort;
    res_valid_next  = out_load ? 1'b0 : res_valid;
    res_status_next = res_status;
    res_data_next   = res_data;
    res_count_next  = res_count;

    cmd.op     = sle_pkg::CELL_HOLD;
    cmd.pos    = IW'(position);
    cmd.count  = count;
    cmd.parity = round[0];
    cmd.by_tag = !is_sort;
    cmd.word   = DW'(value);

    case (state)
      sle_pkg::ST_IDLE: begin
        if (accept) begin
          res_valid_next  = 1'b1;
          res_status_next = sle_pkg::STAT_OK;
          res_data_next   = '0;
          case (opcode)
            sle_pkg::OP_APPEND: begin
              if (full) begin
                res_status_next = sle_pkg::STAT_FULL;
              end else begin
                cmd.op     = sle_pkg::CELL_APPEND;
                count_next = count + CW'(1);
              end
            end
            sle_pkg::OP_INSERT: begin
              if (full) begin
                res_status_next = sle_pkg::STAT_FULL;
              end else if (!pos_ok) begin
                res_status_next = sle_pkg::STAT_RANGE;
              end else begin
                cmd.op     = sle_pkg::CELL_INSERT;
                count_next = count + CW'(1);
              end
            end
            sle_pkg::OP_DELETE: begin
              if (count == '0) begin
                res_status_next = sle_pkg::STAT_EMPTY;
              end else if (!pos_ok) begin
                res_status_next = sle_pkg::STAT_RANGE;
              end else begin
                cmd.op     = sle_pkg::CELL_DELETE;
                count_next = count - CW'(1);
              end
            end
            sle_pkg::OP_READ: begin
              if (count == '0) begin
                res_status_next = sle_pkg::STAT_EMPTY;
              end else if (!pos_ok) begin
                res_status_next = sle_pkg::STAT_RANGE;
              end else begin
                res_data_next = sle_pkg::VALUE_W'($signed(word_chain[IW'(position)]));
              end
            end
            sle_pkg::OP_REVERSE, sle_pkg::OP_SORT: begin
              if (count > CW'(1)) begin
                cmd.op         = sle_pkg::CELL_TAG_INIT;
                state_next     = sle_pkg::ST_RUN;
                round_next     = '0;
                is_sort_next   = (opcode == sle_pkg::OP_SORT);
                res_valid_next = 1'b0;
              end
            end
            default: begin
              res_status_next = sle_pkg::STAT_OK;
            end
          endcase
          res_count_next = count_next;
        end
      end
      sle_pkg::ST_RUN: begin
        cmd.op     = sle_pkg::CELL_STEP;
        round_next = round + CW'(1);
        // n rounds of odd-even exchange order n entries
        if (round == count - CW'(1)) begin
          state_next      = sle_pkg::ST_IDLE;
          res_valid_next  = 1'b1;
          res_status_next = sle_pkg::STAT_OK;
          res_data_next   = '0;
          res_count_next  = count;
        end
      end
      default: begin
        state_next = sle_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sle_pkg::ST_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      res_valid <= res_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    round      <= round_next;
    is_sort    <= is_sort_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
    res_count  <= res_count_next;
    if (out_load) begin
      status      <= res_status;
      read_data   <= res_data;
      entry_count <= sle_pkg::COUNT_OUT_W'(res_count);
    end
  end

  // --------------------------------------------------------------------------
  // row of cells
  // --------------------------------------------------------------------------
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [DW-1:0] lw;
    logic [IW-1:0] lt;
    logic          ls;
    logic [DW-1:0] rw;
    logic [IW-1:0] rt;

    if (gi == 0) begin : g_first
      assign lw = '0;
      assign lt = '0;
      assign ls = 1'b0;
    end else begin : g_mid
      assign lw = word_chain[gi-1];
      assign lt = tag_chain[gi-1];
      assign ls = swap_chain[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_last
      assign rw = '0;
      assign rt = '0;
    end else begin : g_inner
      assign rw = word_chain[gi+1];
      assign rt = tag_chain[gi+1];
    end

    sle_cell u_cell (
      .clk        (clk),
      .idx        (IW'(gi)),
      .cmd        (cmd),
      .left_word  (lw),
      .left_tag   (lt),
      .left_swap  (ls),
      .right_word (rw),
      .right_tag  (rt),
      .word       (word_chain[gi]),
      .tag        (tag_chain[gi]),
      .swap_right (swap_chain[gi])
    );
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sle_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks of the sequential list engine, bound to the top level.
// ----------------------------------------------------------------------------
module sle_checker (
  input wire                                   clk,
  input wire                                   rst,
  input wire                                   out_valid,
  input wire                                   out_stall,
  input wire [sle_pkg::STATUS_W-1:0]           status,
  input wire [sle_pkg::VALUE_W-1:0]            read_data,
  input wire [sle_pkg::COUNT_OUT_W-1:0]        entry_count
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({status, read_data, entry_count}))
    else $error("result beat changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(entry_count) <= sle_pkg::DEPTH)
    else $error("entry count beyond depth");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != sle_pkg::STAT_OK) |-> read_data == '0)
    else $error("read data on a failed operation");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == sle_pkg::STAT_EMPTY) |-> entry_count == '0)
    else $error("empty status with entries present");

endmodule

bind sequential_list_engine_core sle_checker u_sle_checker (.*);
`default_nettype wire
